### src/nip_pkg.sv
// Shared types and constants for the navigation input encoder qualifier.
// Holds the command, step and action codes, the reset values and the result type.
// No dependencies.
`default_nettype none

package nip_pkg;

    localparam int unsigned TimeW      = 32;
    localparam int unsigned RepeatW    = 16;
    localparam int unsigned EncLockW   = 8;
    localparam int unsigned CfgIdxW    = 2;
    localparam int unsigned CfgDataW   = 16;

    localparam logic [CfgIdxW-1:0] CFG_REPEAT_LOCKOUT  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_ENCODER_LOCKOUT = 2'd1;

    localparam logic [RepeatW-1:0]  REPEAT_LOCKOUT_RST  = 16'd200;
    localparam logic [EncLockW-1:0] ENCODER_LOCKOUT_RST = 8'd4;

    typedef enum logic [1:0] {
        CMD_READ_ACTION = 2'd0,
        CMD_FLUSH       = 2'd1,
        CMD_QUERY_UP    = 2'd2,
        CMD_QUERY_DOWN  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2
    } step_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_UP    = 3'd1,
        ACT_DOWN  = 3'd2,
        ACT_ENTER = 3'd3,
        ACT_BACK  = 3'd4
    } action_t;

    typedef struct packed {
        logic [2:0] action;
        logic       query_hit;
        logic       enter_held;
        logic       back_held;
    } result_t;

endpackage

`default_nettype wire

### src/nav_input_encoder_qualifier_core.sv
// Top level of the navigation input encoder qualifier: button edge detection,
// encoder step capture with lockouts, and a two-entry output stage.
// Depends on nip_pkg.
//
// Throughput: one item per cycle while the skid register is empty; the
// next state is computed in the same cycle an item is accepted, so items
// may follow each other back to back. Reset: aresetn is synchronous and
// active low; it restores both lockout registers to their defaults and
// resets all qualifier state and the valid flags of the output stage.
`default_nettype none

module nav_input_encoder_qualifier_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    // Configuration write port.
    input  wire logic                          cfg_wr_en,
    input  wire logic [nip_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [nip_pkg::CfgDataW-1:0]  cfg_wdata,

    // Input item channel.
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_cmd,
    input  wire logic [nip_pkg::TimeW-1:0]     s_now_ms,
    input  wire logic                          s_enc_clk_level,
    input  wire logic                          s_enc_dt_level,
    input  wire logic                          s_back_level,
    input  wire logic                          s_up_level,
    input  wire logic                          s_down_level,
    input  wire logic                          s_ok_level,
    input  wire logic                          s_enc_switch_level,

    // Result item channel.
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [2:0]                         m_action,
    output logic                               m_query_hit,
    output logic                               m_enter_held,
    output logic                               m_back_held
);

    import nip_pkg::*;

    // Configuration registers.
    logic [RepeatW-1:0]  repeat_lockout_reg;
    logic [EncLockW-1:0] encoder_lockout_reg;

    // Qualifier state.
    logic             prev_clk_reg, prev_clk_next;
    step_t            pending_reg, pending_next;
    logic [TimeW-1:0] last_step_reg, last_step_next;
    logic [TimeW-1:0] last_action_reg, last_action_next;
    logic             back_was_reg, back_was_next;
    logic             up_was_reg, up_was_next;
    logic             down_was_reg, down_was_next;
    logic             enter_was_reg, enter_was_next;

    // Output stage: a result register plus a skid register so that a new item
    // is taken even while a finished result waits on the result channel.
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;

    logic    in_accept;
    logic    out_accept;
    result_t result;

    // Decoded input item.
    cmd_t       cmd;
    logic       back_dn, up_dn, down_dn, enter_dn;
    logic       sample_enc;
    logic       clk_changed;
    logic       step_taken;
    step_t      pend_sampled;
    logic       prev_clk_sampled;
    logic [TimeW-1:0] step_elapsed;
    logic [TimeW-1:0] action_elapsed;
    logic       can_act;
    logic [2:0] action;
    logic       hit;
    logic       query_held;
    step_t      query_want;

    assign s_ready    = ~skid_valid_reg;
    assign in_accept  = s_valid & s_ready;
    assign out_accept = out_valid_reg & m_ready;

    assign cmd      = cmd_t'(s_cmd);
    assign back_dn  = ~s_back_level;
    assign up_dn    = ~s_up_level;
    assign down_dn  = ~s_down_level;
    assign enter_dn = ~s_ok_level | ~s_enc_switch_level;

    // The encoder is looked at on a read, and on a query only when the
    // queried button is not held; a flush never samples it.
    always_comb begin
        query_held = 1'b0;
        query_want = STEP_UP;
        sample_enc = 1'b0;
        unique case (cmd)
            CMD_READ_ACTION: begin
                sample_enc = 1'b1;
            end
            CMD_FLUSH: begin
                sample_enc = 1'b0;
            end
            CMD_QUERY_UP: begin
                query_held = up_dn;
                query_want = STEP_UP;
                sample_enc = ~up_dn;
            end
            CMD_QUERY_DOWN: begin
                query_held = down_dn;
                query_want = STEP_DOWN;
                sample_enc = ~down_dn;
            end
            default: begin
                sample_enc = 1'b0;
            end
        endcase
    end

    // Encoder step capture: a falling clock edge after the step lockout has
    // run out records a step whose direction follows the data line.
    assign step_elapsed     = s_now_ms - last_step_reg;
    assign clk_changed      = s_enc_clk_level != prev_clk_reg;
    assign step_taken       = sample_enc & clk_changed & ~s_enc_clk_level
                              & (step_elapsed > {{(TimeW-EncLockW){1'b0}}, encoder_lockout_reg});
    assign pend_sampled     = step_taken ? (s_enc_dt_level ? STEP_DOWN : STEP_UP) : pending_reg;
    assign prev_clk_sampled = (sample_enc & clk_changed) ? s_enc_clk_level : prev_clk_reg;

    // Time since the last emitted action, modulo 2^32.
    assign action_elapsed = s_now_ms - last_action_reg;
    assign can_act        = action_elapsed >= {{(TimeW-RepeatW){1'b0}}, repeat_lockout_reg};

    always_comb begin
        prev_clk_next    = prev_clk_sampled;
        pending_next     = pend_sampled;
        last_step_next   = step_taken ? s_now_ms : last_step_reg;
        last_action_next = last_action_reg;
        back_was_next    = back_was_reg;
        up_was_next      = up_was_reg;
        down_was_next    = down_was_reg;
        enter_was_next   = enter_was_reg;
        action           = ACT_NONE;
        hit              = 1'b0;

        unique case (cmd)
            CMD_READ_ACTION: begin
                // Press edges win over a pending encoder step, in the order
                // back, up, down, enter.
                if (can_act) begin
                    if (back_dn && !back_was_reg) begin
                        action = ACT_BACK;
                    end else if (up_dn && !up_was_reg) begin
                        action = ACT_UP;
                    end else if (down_dn && !down_was_reg) begin
                        action = ACT_DOWN;
                    end else if (enter_dn && !enter_was_reg) begin
                        action = ACT_ENTER;
                    end else if (pend_sampled == STEP_UP) begin
                        action       = ACT_UP;
                        pending_next = STEP_NONE;
                    end else if (pend_sampled == STEP_DOWN) begin
                        action       = ACT_DOWN;
                        pending_next = STEP_NONE;
                    end
                end
                back_was_next  = back_dn;
                up_was_next    = up_dn;
                down_was_next  = down_dn;
                enter_was_next = enter_dn;
                if (action != ACT_NONE) begin
                    last_action_next = s_now_ms;
                end
            end
            CMD_FLUSH: begin
                // Resynchronize to the current line levels.
                pending_next     = STEP_NONE;
                prev_clk_next    = s_enc_clk_level;
                back_was_next    = back_dn;
                up_was_next      = up_dn;
                down_was_next    = down_dn;
                enter_was_next   = enter_dn;
                last_action_next = s_now_ms;
            end
            CMD_QUERY_UP, CMD_QUERY_DOWN: begin
                // A held button answers at once and leaves the state alone;
                // otherwise a matching pending step is consumed.
                if (query_held) begin
                    hit = 1'b1;
                end else if (pend_sampled == query_want) begin
                    hit              = 1'b1;
                    pending_next     = STEP_NONE;
                    last_action_next = s_now_ms;
                end
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    always_comb begin
        result.action     = action;
        result.query_hit  = hit;
        result.enter_held = enter_dn;
        result.back_held  = back_dn;
    end

    // Output stage steering. A new result goes to the result register when it
    // is empty or being drained and the skid register is empty; otherwise it
    // lands in the skid register, which refills the result register later.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_accept) begin
            out_valid_next = 1'b0;
        end
        if (out_accept && skid_valid_reg) begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (in_accept) begin
            if (!out_valid_next) begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_lockout_reg  <= REPEAT_LOCKOUT_RST;
            encoder_lockout_reg <= ENCODER_LOCKOUT_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_REPEAT_LOCKOUT) begin
                repeat_lockout_reg <= cfg_wdata[RepeatW-1:0];
            end else if (cfg_index == CFG_ENCODER_LOCKOUT) begin
                encoder_lockout_reg <= cfg_wdata[EncLockW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_clk_reg    <= 1'b1;
            pending_reg     <= STEP_NONE;
            last_step_reg   <= '0;
            last_action_reg <= '0;
            back_was_reg    <= 1'b0;
            up_was_reg      <= 1'b0;
            down_was_reg    <= 1'b0;
            enter_was_reg   <= 1'b0;
        end else if (in_accept) begin
            prev_clk_reg    <= prev_clk_next;
            pending_reg     <= pending_next;
            last_step_reg   <= last_step_next;
            last_action_reg <= last_action_next;
            back_was_reg    <= back_was_next;
            up_was_reg      <= up_was_next;
            down_was_reg    <= down_was_next;
            enter_was_reg   <= enter_was_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_action     = out_data_reg.action;
    assign m_query_hit  = out_data_reg.query_hit;
    assign m_enter_held = out_data_reg.enter_held;
    assign m_back_held  = out_data_reg.back_held;

endmodule

`default_nettype wire
